// ----- rtl/aac_pkg.sv -----
package aac_pkg;

    // Code entry and card compare sizes.
    localparam int CODE_LENGTH   = 4;
    localparam int CARD_ID_BYTES = 4;
    localparam int CNT_W         = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W         = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_POWER_KEY       = 3'd0;
    localparam logic [2:0] REG_SELECT_KEY      = 3'd1;
    localparam logic [2:0] REG_PASS_CODE       = 3'd2;
    localparam logic [2:0] REG_ADMIN_CARD_ID   = 3'd3;
    localparam logic [2:0] REG_SOUND_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_IR_HOLDOFF_MS   = 3'd5;
    localparam logic [2:0] REG_BLINK_HALF_MS   = 3'd6;

    // Register reset values.
    localparam logic [7:0]  RST_POWER_KEY       = 8'd69;
    localparam logic [7:0]  RST_SELECT_KEY      = 8'd64;
    localparam logic [31:0] RST_PASS_CODE       = 32'h1616_1616;
    localparam logic [31:0] RST_ADMIN_CARD_ID   = 32'hA18E_0F1D;
    localparam logic [9:0]  RST_SOUND_THRESHOLD = 10'd100;
    localparam logic [15:0] RST_IR_HOLDOFF_MS   = 16'd300;
    localparam logic [14:0] RST_BLINK_HALF_MS   = 15'd1000;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_OFFLINE = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_ARMED   = 2'd2,
        MODE_ALARM   = 2'd3
    } mode_t;

    // Mode last drawn on the display; this value means nothing drawn yet.
    localparam logic [2:0] SHOWN_NONE = 3'd4;

    typedef struct packed {
        logic [7:0]  power_key;
        logic [7:0]  select_key;
        logic [31:0] pass_code;
        logic [31:0] admin_card_id;
        logic [9:0]  sound_threshold;
        logic [15:0] ir_holdoff_ms;
        logic [14:0] blink_half_ms;
    } cfg_t;

    typedef struct packed {
        logic            ir_valid;
        logic [7:0]      ir_command;
        logic [3:0]      card_size;
        logic [3:0][7:0] card_bytes;
        logic            motion;
        logic [9:0]      sound_level;
        logic [15:0]     elapsed_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] system_state;
        logic       display_inverted;
        logic [7:0] accepted_key;
        logic [2:0] keys_entered;
    } result_t;

    // Byte i of a word, byte 0 in the top bits; bytes past the fourth read as zero.
    function automatic logic [7:0] word_byte(input logic [31:0] word, input int i);
        logic [31:0] sh;
        sh = 32'd0;
        if (i < 4) begin
            sh = word >> (24 - 8 * i);
        end
        return sh[7:0];
    endfunction

endpackage

// ----- rtl/aac_cfg_regs.sv -----
module aac_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_addr,
    input  logic [31:0]       cfg_wdata,
    output aac_pkg::cfg_t     cfg
);

    aac_pkg::cfg_t cfg_reg;

    // Register file; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_key       <= aac_pkg::RST_POWER_KEY;
            cfg_reg.select_key      <= aac_pkg::RST_SELECT_KEY;
            cfg_reg.pass_code       <= aac_pkg::RST_PASS_CODE;
            cfg_reg.admin_card_id   <= aac_pkg::RST_ADMIN_CARD_ID;
            cfg_reg.sound_threshold <= aac_pkg::RST_SOUND_THRESHOLD;
            cfg_reg.ir_holdoff_ms   <= aac_pkg::RST_IR_HOLDOFF_MS;
            cfg_reg.blink_half_ms   <= aac_pkg::RST_BLINK_HALF_MS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                aac_pkg::REG_POWER_KEY:       cfg_reg.power_key       <= cfg_wdata[7:0];
                aac_pkg::REG_SELECT_KEY:      cfg_reg.select_key      <= cfg_wdata[7:0];
                aac_pkg::REG_PASS_CODE:       cfg_reg.pass_code       <= cfg_wdata;
                aac_pkg::REG_ADMIN_CARD_ID:   cfg_reg.admin_card_id   <= cfg_wdata;
                aac_pkg::REG_SOUND_THRESHOLD: cfg_reg.sound_threshold <= cfg_wdata[9:0];
                aac_pkg::REG_IR_HOLDOFF_MS:   cfg_reg.ir_holdoff_ms   <= cfg_wdata[15:0];
                aac_pkg::REG_BLINK_HALF_MS:   cfg_reg.blink_half_ms   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/aac_core.sv -----
module aac_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  aac_pkg::cfg_t    cfg,
    input  aac_pkg::item_t   item,
    output aac_pkg::result_t result
);

    logic [31:0]                 clock_ms_reg, clock_ms_next;
    logic [31:0]                 last_key_time_reg, last_key_time_next;
    logic [31:0]                 last_blink_time_reg, last_blink_time_next;
    aac_pkg::mode_t              mode_reg, mode_next;
    logic [2:0]                  shown_mode_reg, shown_mode_next;
    logic [aac_pkg::CNT_W-1:0]   key_count_reg, key_count_next;
    logic                        inverted_reg, inverted_next;
    logic [7:0]                  keys_reg [aac_pkg::CODE_LENGTH];
    logic [7:0]                  keys_next [aac_pkg::CODE_LENGTH];

    logic [31:0] key_age;
    logic [31:0] blink_age;
    logic        key_taken;
    logic [7:0]  key;
    logic        code_ok;
    logic        card_ok;
    logic        disarm;

    // Clock advance and IR hold-off.
    always_comb begin
        clock_ms_next = clock_ms_reg + 32'(item.elapsed_ms);
        key_age       = clock_ms_next - last_key_time_reg;
        blink_age     = clock_ms_next - last_blink_time_reg;
        key_taken     = item.ir_valid && (key_age >= 32'(cfg.ir_holdoff_ms));
        key           = key_taken ? item.ir_command : 8'd0;
    end

    // Code buffer compare against pass_code, and card id compare.
    always_comb begin
        code_ok = 1'b1;
        for (int i = 0; i < aac_pkg::CODE_LENGTH; i++) begin
            if (keys_reg[i] != aac_pkg::word_byte(cfg.pass_code, i)) begin
                code_ok = 1'b0;
            end
        end
        card_ok = (item.card_size >= 4'(aac_pkg::CARD_ID_BYTES));
        for (int i = 0; i < aac_pkg::CARD_ID_BYTES && i < 4; i++) begin
            if (item.card_bytes[i] != aac_pkg::word_byte(cfg.admin_card_id, i)) begin
                card_ok = 1'b0;
            end
        end
    end

    // Mode action for one pass, taken from the mode held at the start.
    always_comb begin
        last_key_time_next   = key_taken ? clock_ms_next : last_key_time_reg;
        last_blink_time_next = last_blink_time_reg;
        mode_next            = mode_reg;
        shown_mode_next      = shown_mode_reg;
        key_count_next       = key_count_reg;
        inverted_next        = inverted_reg;
        keys_next            = keys_reg;
        disarm               = 1'b0;

        case (mode_reg)
            aac_pkg::MODE_OFFLINE: begin
                shown_mode_next = 3'(aac_pkg::MODE_OFFLINE);
                if (key == cfg.power_key) begin
                    mode_next = aac_pkg::MODE_IDLE;
                end
            end
            aac_pkg::MODE_IDLE: begin
                if (shown_mode_reg != 3'(aac_pkg::MODE_IDLE)) begin
                    inverted_next   = 1'b1;
                    shown_mode_next = 3'(aac_pkg::MODE_IDLE);
                end
                if (key == cfg.select_key) begin
                    mode_next = aac_pkg::MODE_ARMED;
                end else if (key == cfg.power_key) begin
                    mode_next = aac_pkg::MODE_OFFLINE;
                end
            end
            default: begin
                if (mode_reg == aac_pkg::MODE_ARMED) begin
                    if (shown_mode_reg != 3'(aac_pkg::MODE_ARMED)) begin
                        inverted_next   = 1'b1;
                        shown_mode_next = 3'(aac_pkg::MODE_ARMED);
                    end
                end else begin
                    // Alarm blink: clear at two half-periods, set at one.
                    shown_mode_next = 3'(aac_pkg::MODE_ALARM);
                    if (blink_age >= 32'({cfg.blink_half_ms, 1'b0})) begin
                        last_blink_time_next = clock_ms_next;
                        inverted_next        = 1'b0;
                    end else if (blink_age >= 32'(cfg.blink_half_ms)) begin
                        inverted_next = 1'b1;
                    end
                end

                // Code entry: store a key, or check and empty a full buffer.
                if (key != 8'd0 && key_count_reg < aac_pkg::CNT_W'(aac_pkg::CODE_LENGTH)) begin
                    keys_next[key_count_reg[aac_pkg::IDX_W-1:0]] = key;
                    key_count_next = key_count_reg + 1'b1;
                end else if (key_count_reg >= aac_pkg::CNT_W'(aac_pkg::CODE_LENGTH)) begin
                    disarm         = code_ok;
                    key_count_next = '0;
                end

                if (disarm || card_ok) begin
                    mode_next = aac_pkg::MODE_IDLE;
                end

                // An armed pass alarms on motion or loud sound, even if disarmed.
                if (mode_reg == aac_pkg::MODE_ARMED &&
                    (item.motion || item.sound_level >= cfg.sound_threshold)) begin
                    mode_next = aac_pkg::MODE_ALARM;
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_ms_reg        <= '0;
            last_key_time_reg   <= '0;
            last_blink_time_reg <= '0;
            mode_reg            <= aac_pkg::MODE_IDLE;
            shown_mode_reg      <= aac_pkg::SHOWN_NONE;
            key_count_reg       <= '0;
            inverted_reg        <= 1'b0;
        end else if (advance) begin
            clock_ms_reg        <= clock_ms_next;
            last_key_time_reg   <= last_key_time_next;
            last_blink_time_reg <= last_blink_time_next;
            mode_reg            <= mode_next;
            shown_mode_reg      <= shown_mode_next;
            key_count_reg       <= key_count_next;
            inverted_reg        <= inverted_next;
        end
    end

    // Key buffer contents; only written entries are ever compared.
    always_ff @(posedge aclk) begin
        if (advance) begin
            keys_reg <= keys_next;
        end
    end

    assign result.system_state     = mode_next;
    assign result.display_inverted = inverted_next;
    assign result.accepted_key     = key;
    assign result.keys_entered     = 3'(key_count_next);

endmodule

// ----- rtl/alarm_arming_controller.sv -----
// Channel   Dir  Ports                      Contents
// s_        in   s_tvalid s_tready          one polling pass: IR, card, sensors, elapsed time
//                s_tdata s_tuser
// m_        out  m_tvalid m_tready m_tdata  one result per pass: state, display, key, count
// cfg_      in   cfg_wr_en cfg_addr         register write, no handshake
//                cfg_wdata
//
// One beat is taken per clock unless the input side stalls; a result passes the input
// register and then the output register, with the pass itself as combinational logic
// between them and the controller state updated in the same cycle as the output register.
// Synchronous active-low reset restores the idle state and the register defaults.
// A stalled result holds in the output register while the input register still
// takes one beat, so the input side stalls only when both are full.
module alarm_arming_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] ir_command, [11:8] card_size, [19:12] card_byte0, [27:20] card_byte1,
    // [35:28] card_byte2, [43:36] card_byte3, [44] motion, [54:45] sound_level,
    // [70:55] elapsed_ms, [71] zero
    input  logic [71:0] s_tdata,
    // [0] ir_valid
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] system_state, [2] display_inverted, [10:3] accepted_key,
    // [13:11] keys_entered, [15:14] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    aac_pkg::cfg_t    cfg;
    aac_pkg::item_t   item_reg, item_next;
    aac_pkg::result_t core_result;
    aac_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;

    // Pass moves from the input register to the output register when it has room.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Unpack the input beat.
    always_comb begin
        item_next.ir_valid      = s_tuser;
        item_next.ir_command    = s_tdata[7:0];
        item_next.card_size     = s_tdata[11:8];
        item_next.card_bytes[0] = s_tdata[19:12];
        item_next.card_bytes[1] = s_tdata[27:20];
        item_next.card_bytes[2] = s_tdata[35:28];
        item_next.card_bytes[3] = s_tdata[43:36];
        item_next.motion        = s_tdata[44];
        item_next.sound_level   = s_tdata[54:45];
        item_next.elapsed_ms    = s_tdata[70:55];
    end

    // Input and output valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
        if (advance) begin
            result_reg <= core_result;
        end
    end

    aac_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg.keys_entered, result_reg.accepted_key,
                       result_reg.display_inverted, result_reg.system_state};

endmodule

// ----- rtl/aac_checker.sv -----
module aac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With the output side empty, the input side never stalls.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // The code buffer never reports more keys than it holds.
    a_key_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:11] <= 3'(aac_pkg::CODE_LENGTH))
        else $error("keys_entered out of range");

    // An input beat accepted while the output side is empty always yields a valid result
    // once it has passed the input and output registers.
    a_beat_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("accepted beat produced no result");

endmodule

bind alarm_arming_controller aac_checker u_aac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
